### sv/dual_iso_cube_component_labeler_defines.svh
// Assertion macros for the dual iso cube component labeler.
`ifndef DUAL_ISO_CUBE_COMPONENT_LABELER_DEFINES_SVH
`define DUAL_ISO_CUBE_COMPONENT_LABELER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DICL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define DICL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dicl_pkg.sv
// Shared constants and types for the dual iso cube component labeler.
package dicl_pkg;

    localparam int DICL_DIM    = 3;   // cube dimension, 1..4
    localparam int DICL_QDEPTH = 2;   // front-to-back request queue depth

    localparam int IN_W    = 8;
    localparam int NUM_W   = 3;
    localparam int LABEL_W = 16;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### sv/dicl_front.sv
// Front end: takes requests, applies the opposite-corner split, builds the negative mask.
module dicl_front #(
    parameter int DIM = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [dicl_pkg::IN_W-1:0] i_cube_index,
    input  logic                     i_split_en,
    input  dicl_pkg::t_q_status      i_q_stat,
    output logic                     o_busy,
    output logic                     o_push,
    output logic [(1 << DIM):0]      o_push_data
);
    import dicl_pkg::*;

    localparam int NC   = 1 << DIM;
    localparam int IN_C = (NC < IN_W) ? NC : IN_W;

    logic [NC-1:0] pos;
    logic [NC-1:0] low_clr;
    logic [NC-1:0] mirror;
    logic          two_hot;
    logic          split;
    logic [NC-1:0] neg;
    logic          accept;

    logic          r_valid;
    logic [NC:0]   r_item;

    always_comb begin
        pos = '0;
        pos[IN_C-1:0] = i_cube_index[IN_C-1:0];
        for (int k = 0; k < NC; k++) begin
            mirror[k] = pos[NC-1-k];
        end
    end

    // exactly two set bits: clearing the lowest leaves a single bit
    assign low_clr = pos & (pos - NC'(1));
    assign two_hot = (low_clr != '0) && ((low_clr & (low_clr - NC'(1))) == '0);
    assign split   = i_split_en && two_hot && (mirror == pos);
    assign neg     = split ? pos : ~pos;

    assign o_busy      = r_valid && i_q_stat.full;
    assign accept      = i_start && !o_busy;
    assign o_push      = r_valid && !i_q_stat.full;
    assign o_push_data = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= {split, neg};
        end
    end

endmodule

### sv/dicl_queue.sv
// Small request queue between the front end and the labeling engine.
module dicl_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_push_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_pop_data,
    output dicl_pkg::t_q_status o_stat
);
    import dicl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### sv/dicl_back.sv
// Labeling engine: grows one component of negative corners a step per cycle.
module dicl_back #(
    parameter int DIM = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dicl_pkg::t_q_status          i_q_stat,
    input  logic [(1 << DIM):0]          i_pop_data,
    output logic                         o_pop,
    output logic                         o_done,
    output logic [dicl_pkg::NUM_W-1:0]   o_num_isovertices,
    output logic [dicl_pkg::IN_W-1:0]    o_negative_mask,
    output logic [dicl_pkg::LABEL_W-1:0] o_isovertex_labels,
    output logic                         o_split_applied
);
    import dicl_pkg::*;

    localparam int NC    = 1 << DIM;
    localparam int OUT_C = (NC < IN_W) ? NC : IN_W;
    localparam int CNT_W = $clog2(NC / 2 + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GROW
    } t_state;

    t_state               r_state, n_state;
    logic [NC-1:0]        r_neg, n_neg;
    logic [NC-1:0]        r_left, n_left;
    logic [NC-1:0]        r_set, n_set;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_done, n_done;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [IN_W-1:0]      r_mask, n_mask;
    logic [LABEL_W-1:0]   r_labels, n_labels;
    logic                 r_split, n_split;

    logic [NC-1:0]        grown;
    logic [NC-1:0]        lowest;
    logic [CNT_W+2:0]     cnt_ext;
    logic [CNT_W+1:0]     lab_ext;

    // one breadth step: add every cube neighbor, keep negatives
    always_comb begin
        grown = r_set;
        for (int j = 0; j < NC; j++) begin
            for (int d = 0; d < DIM; d++) begin
                if (r_set[j ^ (1 << d)]) begin
                    grown[j] = 1'b1;
                end
            end
        end
        grown = grown & r_neg;
    end

    assign lowest  = r_left & (~r_left + NC'(1));
    assign cnt_ext = (CNT_W + 3)'(r_count);
    assign lab_ext = (CNT_W + 2)'(r_count) - (CNT_W + 2)'(1);
    assign o_pop   = (r_state == ST_IDLE) && !i_q_stat.empty;

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_left   = r_left;
        n_set    = r_set;
        n_count  = r_count;
        n_done   = 1'b0;
        n_num    = r_num;
        n_mask   = r_mask;
        n_labels = r_labels;
        n_split  = r_split;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_neg    = i_pop_data[NC-1:0];
                    n_left   = i_pop_data[NC-1:0];
                    n_split  = i_pop_data[NC];
                    n_count  = '0;
                    n_labels = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_left == '0) begin
                    n_done  = 1'b1;
                    n_num   = cnt_ext[NUM_W-1:0];
                    n_mask  = '0;
                    n_mask[OUT_C-1:0] = r_neg[OUT_C-1:0];
                    n_state = ST_IDLE;
                end else begin
                    n_set   = lowest;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_GROW;
                end
            end
            ST_GROW: begin
                if (grown == r_set) begin
                    for (int k = 0; k < OUT_C; k++) begin
                        if (r_set[k]) begin
                            n_labels[2*k +: 2] = lab_ext[1:0];
                        end
                    end
                    n_left  = r_left & ~r_set;
                    n_state = ST_SCAN;
                end else begin
                    n_set = grown;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_neg    <= n_neg;
        r_left   <= n_left;
        r_set    <= n_set;
        r_count  <= n_count;
        r_num    <= n_num;
        r_mask   <= n_mask;
        r_labels <= n_labels;
        r_split  <= n_split;
    end

    assign o_done             = r_done;
    assign o_num_isovertices  = r_num;
    assign o_negative_mask    = r_mask;
    assign o_isovertex_labels = r_labels;
    assign o_split_applied    = r_split;

endmodule

### sv/dual_iso_cube_component_labeler.sv
// Top level of the dual iso cube component labeler.
//
// channel   ports                                   handshake
// -------   -------------------------------------   ------------------------------
// request   i_cube_index                            taken when start && !busy
// result    o_num_isovertices, o_negative_mask,     o_done, one cycle, no stall
//           o_isovertex_labels, o_split_applied
// config    i_cfg_wdata (opposite_split)            written when i_cfg_we
//
// A request is classified and registered in the front end, then queued.
// The engine pops it in ST_IDLE, then seeds each component in ST_SCAN and grows it
// in ST_GROW one breadth step over the cube graph at a time, until a step adds nothing;
// a last ST_SCAN with no corners left registers the result and raises o_done.
// busy rises only while the front register holds a request and the queue is full.
// Reset (synchronous, active low) empties the queue and sets opposite_split to 1.
`include "dual_iso_cube_component_labeler_defines.svh"

module dual_iso_cube_component_labeler #(
    parameter int DIM    = dicl_pkg::DICL_DIM,
    parameter int QDEPTH = dicl_pkg::DICL_QDEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dicl_pkg::IN_W-1:0]    i_cube_index,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    output logic                         o_done,
    output logic [dicl_pkg::NUM_W-1:0]   o_num_isovertices,
    output logic [dicl_pkg::IN_W-1:0]    o_negative_mask,
    output logic [dicl_pkg::LABEL_W-1:0] o_isovertex_labels,
    output logic                         o_split_applied
);
    import dicl_pkg::*;

    localparam int NC = 1 << DIM;

    logic          r_split_en;
    logic          push, pop;
    logic [NC:0]   push_data, pop_data;
    t_q_status     q_stat;

    // opposite_split; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_split_en <= i_cfg_wdata;
        end
    end

    dicl_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cube_index (i_cube_index),
        .i_split_en   (r_split_en),
        .i_q_stat     (q_stat),
        .o_busy       (busy),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    dicl_queue #(
        .WIDTH (NC + 1),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    dicl_back #(
        .DIM (DIM)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_stat           (q_stat),
        .i_pop_data         (pop_data),
        .o_pop              (pop),
        .o_done             (o_done),
        .o_num_isovertices  (o_num_isovertices),
        .o_negative_mask    (o_negative_mask),
        .o_isovertex_labels (o_isovertex_labels),
        .o_split_applied    (o_split_applied)
    );

    // engine returns to idle after each result, so strobes never abut
    `DICL_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe repeated")
    // a split result keeps exactly the two opposite corners negative
    `DICL_ASSERT_IMPL(a_split_two, i_clk, i_rst_n, o_done && o_split_applied, $countones(o_negative_mask) == 2, "split result without two negative corners")
    // no components means no negative corners
    `DICL_ASSERT_IMPL(a_empty_mask, i_clk, i_rst_n, o_done && (o_num_isovertices == 3'd0), o_negative_mask == 8'd0, "zero count with negative corners")

endmodule

### sim/dual_iso_cube_component_labeler_tb.sv
// Self-checking testbench for the dual iso cube component labeler.
`timescale 1ns / 100ps

module dual_iso_cube_component_labeler_tb;
    import dicl_pkg::*;

    // Run limits: the watchdog bound, the drain wait after the last result and the
    // longest idle gap drawn between requests.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;    // engine latency with margin
    localparam int MAX_GAP      = 17;

    // One predicted result.
    typedef struct packed {
        logic [NUM_W-1:0]   num_isovertices;
        logic [IN_W-1:0]    negative_mask;
        logic [LABEL_W-1:0] isovertex_labels;
        logic               split_applied;
    } t_cube_labels;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [IN_W-1:0]    i_cube_index = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               o_done;
    logic [NUM_W-1:0]   o_num_isovertices;
    logic [IN_W-1:0]    o_negative_mask;
    logic [LABEL_W-1:0] o_isovertex_labels;
    logic               o_split_applied;

    t_cube_labels pending_labels[$];   // predictions of requests in flight, oldest first
    t_cube_labels oldest;
    logic         split_enable = 1'b1; // local copy of opposite_split, reset value is 1
    int           mismatch_count = 0;
    int           cycle_count = 0;

    dual_iso_cube_component_labeler dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cube_index       (i_cube_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_done             (o_done),
        .o_num_isovertices  (o_num_isovertices),
        .o_negative_mask    (o_negative_mask),
        .o_isovertex_labels (o_isovertex_labels),
        .o_split_applied    (o_split_applied)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_labels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Predictor. Flood-fills the negative corners on the cube graph, seeding
    // each component at its lowest corner, so components come out numbered in
    // ascending corner order.
    function automatic t_cube_labels label_cube(input logic [IN_W-1:0] cube,
                                                input logic split_en);
        int          dim;
        int          nc;
        int          count;
        int          i;
        int          j;
        int          k;
        int          d;
        int          comp[16];
        int unsigned all_mask;
        int unsigned pos;
        int unsigned neg;
        int unsigned left;
        int unsigned grp;
        int unsigned grown;
        int unsigned mirror;
        int unsigned labels;
        logic        split;
        t_cube_labels r;

        dim = (DICL_DIM < 1) ? 1 : ((DICL_DIM > 4) ? 4 : DICL_DIM);
        nc = 1 << dim;
        all_mask = (32'd1 << nc) - 32'd1;
        // Pattern bits above the last corner are dropped; at DIM=4 the upper
        // corners have no input bit and so count as negative.
        pos = 32'(cube) & all_mask;

        mirror = 0;
        for (k = 0; k < nc; k++) begin
            mirror = (mirror << 1) | ((pos >> k) & 32'd1);
        end
        // Two positive corners on a main diagonal: flip every sign.
        split = split_en && ($countones(pos) == 2) && (mirror == pos);
        if (split) begin
            pos = ~pos & all_mask;
        end
        neg = ~pos & all_mask;

        for (i = 0; i < 16; i++) begin
            comp[i] = 0;
        end
        count = 0;
        left = neg;
        for (i = 0; i < nc; i++) begin
            if (left[i]) begin
                count++;
                grp = 32'd1 << i;
                forever begin
                    grown = grp;
                    for (j = 0; j < nc; j++) begin
                        if (grp[j]) begin
                            for (d = 0; d < dim; d++) begin
                                grown |= 32'd1 << ((j ^ (1 << d)) & 15);
                            end
                        end
                    end
                    grown &= neg;
                    if (grown == grp) break;
                    grp = grown;
                end
                for (j = 0; j < nc; j++) begin
                    if (grp[j]) comp[j] = count;
                end
                left &= ~grp;
            end
        end

        // Only the eight corners with a field slot get a label; two bits each,
        // so any wider label wraps.
        labels = 0;
        for (i = 0; i < 8 && i < nc; i++) begin
            if (neg[i]) begin
                labels |= (32'(comp[i] - 1) & 32'd3) << (2 * i);
            end
        end

        r.num_isovertices  = count[NUM_W-1:0];
        r.negative_mask    = neg[IN_W-1:0];
        r.isovertex_labels = labels[LABEL_W-1:0];
        r.split_applied    = split;
        return r;
    endfunction

    // Result checker. o_done cannot be held off, so every strobe is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_labels.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: num=%0d neg=%h lab=%h",
                                        o_num_isovertices, o_negative_mask,
                                        o_isovertex_labels));
            end else begin
                oldest = pending_labels.pop_front();
                if (o_num_isovertices !== oldest.num_isovertices)
                    flag_mismatch($sformatf("num_isovertices %0d, predicted %0d",
                                            o_num_isovertices, oldest.num_isovertices));
                if (o_negative_mask !== oldest.negative_mask)
                    flag_mismatch($sformatf("negative_mask %h, predicted %h",
                                            o_negative_mask, oldest.negative_mask));
                if (o_isovertex_labels !== oldest.isovertex_labels)
                    flag_mismatch($sformatf("isovertex_labels %h, predicted %h (neg %h)",
                                            o_isovertex_labels, oldest.isovertex_labels,
                                            oldest.negative_mask));
                if (o_split_applied !== oldest.split_applied)
                    flag_mismatch($sformatf("split_applied %b, predicted %b (neg %h)",
                                            o_split_applied, oldest.split_applied,
                                            oldest.negative_mask));
            end
        end
    end

    // Sends one request. Called right after a rising edge. With gap 0 start
    // stays high from the previous request, so it is never lowered and raised
    // in the same step.
    task automatic send_cube(input logic [IN_W-1:0] cube, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cube_index <= cube;
        do @(posedge i_clk); while (busy);
        pending_labels.insert(pending_labels.size(), label_cube(cube, split_enable));
    endtask

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Drops start and waits until every pending result is back, plus the
    // engine latency.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes opposite_split while the block is idle.
    task automatic set_opposite_split(input logic value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        split_enable = value;
    endtask

    // Random pattern, biased toward the diagonal pairs and near-empty or
    // near-full cubes where the split and the component count get interesting.
    function automatic logic [IN_W-1:0] draw_cube();
        int          pick;
        int          k;
        logic [IN_W-1:0] v;
        pick = $urandom_range(0, 9);
        k = $urandom_range(0, 3);
        case (pick)
            0, 1, 2: begin
                v = (8'h01 << k) | (8'h80 >> k);       // diagonally opposite pair
            end
            3, 4: begin
                v = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
            end
            5: begin
                v = ~((8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7)));
            end
            default: begin
                v = IN_W'($urandom);
            end
        endcase
        return v;
    endfunction

    // Directed: extremes, single corners, diagonal pairs (split path) and two
    // of their complements, non-diagonal pairs, a palindrome with four corners,
    // and the two checkerboards that give four isolated components.
    task automatic test_directed();
        logic [IN_W-1:0] list[$];
        int              k;
        list = '{8'h00, 8'hFF, 8'h81, 8'h42, 8'h24, 8'h18, 8'h03, 8'h06,
                 8'h99, 8'h69, 8'h96, 8'h7E, 8'hE7};
        for (k = 0; k < 8; k++) list.insert(list.size(), IN_W'(8'h01 << k));
        foreach (list[k]) send_cube(list[k], draw_gap(k % 3 != 0));
    endtask

    // Diagonal pairs, checkerboards and the two extremes again with the split switched off.
    task automatic test_split_disabled();
        logic [IN_W-1:0] list[$];
        set_opposite_split(1'b0);
        list = '{8'h81, 8'h42, 8'h24, 8'h18, 8'h69, 8'h96, 8'h00, 8'hFF};
        foreach (list[k]) send_cube(list[k], draw_gap(1'b1));
    endtask

    // Random requests in bursts, some bursts back to back so that start stays
    // high into busy, others with random idle gaps.
    task automatic test_random(input int n, input logic split_value);
        int  k;
        bit  idle_on;
        set_opposite_split(split_value);
        idle_on = 1'b1;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
            send_cube(draw_cube(), draw_gap(idle_on));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_split_disabled();
        test_random(300, 1'b1);
        test_random(300, 1'b0);
        test_random(300, 1'b1);
        test_random(250, 1'b0);

        wait_idle();
        if (pending_labels.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_labels.size()));
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/dicl_pkg.sv
sv/dicl_front.sv
sv/dicl_queue.sv
sv/dicl_back.sv
sv/dual_iso_cube_component_labeler.sv
sim/dual_iso_cube_component_labeler_tb.sv
